### design/blz_pkg.sv
// Shared types and constants of the backward LZ decompressor.
package blz_pkg;

  // Default depth of the history memory in bytes.
  localparam int unsigned HistDepthDef = 8192;

  // Width of the length registers and of the position counters.
  localparam int unsigned LenW = 32;

  // Token fields: length and offset both carry a bias of three.
  localparam logic [4:0] TokenLenBias = 5'd3;
  localparam logic [12:0] TokenOfsBias = 13'd3;

  // Flags supplied by one flag byte.
  localparam logic [3:0] FlagsPerByte = 4'd8;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CfgPayloadLen = 1'b0,
    CfgOutputLen  = 1'b1
  } cfg_reg_e;

  // Status codes of a result word.
  typedef enum logic [1:0] {
    StsOk        = 2'd0,
    StsTruncated = 2'd1,
    StsPastEnd   = 2'd2,
    StsOverlap   = 2'd3
  } status_e;

  // Which byte of the stream is expected next.
  typedef enum logic [1:0] {
    PhFlag = 2'd0,
    PhElem = 2'd1,
    PhLow  = 2'd2
  } phase_e;

endpackage

### design/blz_mod.sv
// Wrapped history index step: adds or subtracts an amount modulo the history depth.
module blz_mod #(
  parameter int unsigned Depth = blz_pkg::HistDepthDef
) (
  input  logic [$clog2(Depth)-1:0] idx_i,
  input  logic [$clog2(Depth):0]   amt_i,
  input  logic                     sub_i,
  output logic [$clog2(Depth)-1:0] idx_o
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam logic [IdxW:0] DepthX = (IdxW + 1)'(Depth);

  logic [IdxW:0] sum;
  logic [IdxW:0] diff;

  // The index is below the depth and the amount is at most the depth, so a
  // single correction by the depth brings either result back into range.
  assign sum  = {1'b0, idx_i} + amt_i;
  assign diff = {1'b0, idx_i} - amt_i;

  always_comb begin
    if (sub_i) begin
      idx_o = diff[IdxW] ? IdxW'(diff + DepthX) : diff[IdxW-1:0];
    end else begin
      idx_o = (sum >= DepthX) ? IdxW'(sum - DepthX) : sum[IdxW-1:0];
    end
  end

endmodule

### design/backward_lz_decompressor.sv
// Top level of the backward LZ decompressor.
//
// Compressed bytes arrive from the highest address downward and decoded bytes
// leave with their positions: items count down toward zero, and the bytes of
// a copy leave in ascending positions. A flag byte, a literal or the high byte
// of a copy token is handled as it is accepted; the low byte of a token is
// accepted, then evaluated, then each copied byte takes a history read and a
// history write through the history memory, which has one write port and one
// read port. A token that ends in an error gives its result once the output is
// free. A register write restarts the stream and takes effect at once.
// Decoded bytes are kept in the history memory in decode order, so the ring
// index restarts at zero with each stream. Errors (truncated stream, reference
// past the end, overlapping copy) give one result word with the error status
// and halt until the next register write.
module backward_lz_decompressor #(
  parameter int unsigned HistDepth = blz_pkg::HistDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // Compressed input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  comp_byte_i,
  // Decoded output words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [31:0] out_position_o,
  output logic        last_of_item_o,
  output logic        finished_o,
  output logic [1:0]  status_o
);

  localparam int unsigned IdxW = $clog2(HistDepth);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(HistDepth - 1);

  typedef enum logic [3:0] {
    SqIdle  = 4'b0001,
    SqToken = 4'b0010,
    SqRead  = 4'b0100,
    SqWrite = 4'b1000
  } seq_state_e;

  // Control state
  seq_state_e        state_q, state_d;
  blz_pkg::phase_e   phase_q, phase_d;
  logic [31:0]       pay_len_q, pay_len_d;
  logic [31:0]       out_len_q, out_len_d;
  logic [31:0]       bytes_owed_q, bytes_owed_d;
  logic [31:0]       input_left_q, input_left_d;
  logic [7:0]        flag_bits_q, flag_bits_d;
  logic [3:0]        flags_left_q, flags_left_d;
  logic              halted_q, halted_d;
  logic [IdxW-1:0]   own_idx_q, own_idx_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  // Payload state
  logic [7:0]        tok_hi_q, tok_hi_d;
  logic [7:0]        tok_lo_q, tok_lo_d;
  logic [31:0]       pos_q, pos_d;
  logic [IdxW-1:0]   wr_idx_q, wr_idx_d;
  logic [IdxW-1:0]   rd_idx_q, rd_idx_d;
  logic              fin_copy_q, fin_copy_d;
  logic [7:0]        rd_data_q;
  logic [7:0]        out_byte_q;
  logic [31:0]       out_pos_q;
  logic              out_last_q;
  logic              out_fin_q;
  logic [1:0]        out_sts_q;

  // History memory
  logic [7:0]        hist_mem [HistDepth];
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [7:0]        mem_wdata;

  // Handshake and result emission
  logic              out_free;
  logic              in_acc;
  logic              emit;
  logic [7:0]        e_byte;
  logic [31:0]       e_pos;
  logic              e_last;
  logic              e_fin;
  blz_pkg::status_e  e_sts;

  // Token decode
  logic [4:0]        size_raw;
  logic [4:0]        size;
  logic [4:0]        size_m1;
  logic [12:0]       ofs;
  logic              past_end;
  logic              overlap;
  logic [31:0]       new_owed;
  logic [IdxW:0]     top_amt;
  logic [IdxW:0]     src_amt;
  logic [IdxW-1:0]   top_idx;
  logic [IdxW-1:0]   src_idx;

  // Index helpers and flag advance
  logic [IdxW-1:0]   own_inc;
  logic [IdxW-1:0]   wr_idx_dec;
  logic [IdxW-1:0]   rd_idx_dec;
  logic [3:0]        flags_left_adv;
  blz_pkg::phase_e   phase_adv;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == SqIdle) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // Token fields, clamped length and the two error checks.
  assign size_raw = {1'b0, tok_hi_q[7:4]} + blz_pkg::TokenLenBias;
  assign size     = (bytes_owed_q < {27'd0, size_raw}) ? bytes_owed_q[4:0] : size_raw;
  assign size_m1  = size - 5'd1;
  assign ofs      = {1'b0, tok_hi_q[3:0], tok_lo_q} + blz_pkg::TokenOfsBias;
  assign past_end = ({1'b0, bytes_owed_q} - 33'd1 + {20'd0, ofs}) >= {1'b0, out_len_q};
  assign overlap  = ofs < {8'd0, size};
  assign new_owed = bytes_owed_q - {27'd0, size};

  // The lowest copied position is the last of the copy in decode order, so its
  // ring index lies size - 1 above the next free one; its source lies offset
  // entries back in decode order.
  assign top_amt = (IdxW + 1)'(size_m1);
  assign src_amt = (IdxW + 1)'(ofs);

  blz_mod #(
    .Depth (HistDepth)
  ) u_top_idx (
    .idx_i (own_idx_q),
    .amt_i (top_amt),
    .sub_i (1'b0),
    .idx_o (top_idx)
  );

  blz_mod #(
    .Depth (HistDepth)
  ) u_src_idx (
    .idx_i (top_idx),
    .amt_i (src_amt),
    .sub_i (1'b1),
    .idx_o (src_idx)
  );

  // Wrapped index steps.
  assign own_inc    = (own_idx_q == IdxMax) ? '0 : own_idx_q + 1'b1;
  assign wr_idx_dec = (wr_idx_q == '0) ? IdxMax : wr_idx_q - 1'b1;
  assign rd_idx_dec = (rd_idx_q == '0) ? IdxMax : rd_idx_q - 1'b1;

  // Flag state after a literal or a copy has been completed.
  assign flags_left_adv = (flags_left_q != '0) ? flags_left_q - 1'b1 : '0;
  assign phase_adv      = (flags_left_adv != '0) ? blz_pkg::PhElem : blz_pkg::PhFlag;

  // Sequencer and stream state.
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    pay_len_d    = pay_len_q;
    out_len_d    = out_len_q;
    bytes_owed_d = bytes_owed_q;
    input_left_d = input_left_q;
    flag_bits_d  = flag_bits_q;
    flags_left_d = flags_left_q;
    halted_d     = halted_q;
    own_idx_d    = own_idx_q;
    cnt_d        = cnt_q;
    tok_hi_d     = tok_hi_q;
    tok_lo_d     = tok_lo_q;
    pos_d        = pos_q;
    wr_idx_d     = wr_idx_q;
    rd_idx_d     = rd_idx_q;
    fin_copy_d   = fin_copy_q;
    mem_we       = 1'b0;
    mem_waddr    = wr_idx_q;
    mem_wdata    = rd_data_q;
    emit         = 1'b0;
    e_byte       = '0;
    e_pos        = '0;
    e_last       = 1'b1;
    e_fin        = 1'b0;
    e_sts        = blz_pkg::StsOk;

    unique case (state_q)
      SqIdle: begin
        if (in_acc && !halted_q && (bytes_owed_q != '0)) begin
          if (input_left_q == '0) begin
            emit     = 1'b1;
            e_sts    = blz_pkg::StsTruncated;
            halted_d = 1'b1;
          end else if ((phase_q == blz_pkg::PhElem) && flag_bits_q[7] &&
                       (input_left_q < 32'd2)) begin
            emit     = 1'b1;
            e_sts    = blz_pkg::StsTruncated;
            halted_d = 1'b1;
          end else begin
            input_left_d = input_left_q - 1'b1;
            unique case (phase_q)
              blz_pkg::PhElem: begin
                if (flag_bits_q[7]) begin
                  tok_hi_d = comp_byte_i;
                  phase_d  = blz_pkg::PhLow;
                end else begin
                  // Literal byte goes straight to history and output.
                  mem_we       = 1'b1;
                  mem_waddr    = own_idx_q;
                  mem_wdata    = comp_byte_i;
                  emit         = 1'b1;
                  e_byte       = comp_byte_i;
                  e_pos        = bytes_owed_q - 1'b1;
                  e_fin        = (bytes_owed_q == 32'd1);
                  bytes_owed_d = bytes_owed_q - 1'b1;
                  own_idx_d    = own_inc;
                  flag_bits_d  = {flag_bits_q[6:0], 1'b0};
                  flags_left_d = flags_left_adv;
                  phase_d      = phase_adv;
                  halted_d     = (bytes_owed_q == 32'd1);
                end
              end
              blz_pkg::PhLow: begin
                tok_lo_d = comp_byte_i;
                state_d  = SqToken;
              end
              default: begin
                flag_bits_d  = comp_byte_i;
                flags_left_d = blz_pkg::FlagsPerByte;
                phase_d      = blz_pkg::PhElem;
              end
            endcase
          end
        end
      end

      SqToken: begin
        if (past_end || overlap) begin
          if (out_free) begin
            emit     = 1'b1;
            e_sts    = past_end ? blz_pkg::StsPastEnd : blz_pkg::StsOverlap;
            halted_d = 1'b1;
            state_d  = SqIdle;
          end
        end else begin
          // The copy runs in ascending positions, that is backward in ring order.
          cnt_d        = size;
          pos_d        = new_owed;
          wr_idx_d     = top_idx;
          rd_idx_d     = src_idx;
          bytes_owed_d = new_owed;
          own_idx_d    = top_idx;
          fin_copy_d   = (new_owed == '0);
          state_d      = SqRead;
        end
      end

      SqRead: begin
        state_d = SqWrite;
      end

      SqWrite: begin
        if (out_free) begin
          mem_we   = 1'b1;
          emit     = 1'b1;
          e_byte   = rd_data_q;
          e_pos    = pos_q;
          e_last   = (cnt_q == 5'd1);
          e_fin    = (cnt_q == 5'd1) && fin_copy_q;
          cnt_d    = cnt_q - 1'b1;
          pos_d    = pos_q + 1'b1;
          wr_idx_d = wr_idx_dec;
          rd_idx_d = rd_idx_dec;
          if (cnt_q == 5'd1) begin
            flag_bits_d  = {flag_bits_q[6:0], 1'b0};
            flags_left_d = flags_left_adv;
            phase_d      = phase_adv;
            halted_d     = fin_copy_q;
            own_idx_d    = own_inc;
            state_d      = SqIdle;
          end else begin
            state_d = SqRead;
          end
        end
      end

      default: begin
        state_d = SqIdle;
      end
    endcase

    // A register write restarts the stream.
    if (cfg_we_i) begin
      unique case (blz_pkg::cfg_reg_e'(cfg_idx_i))
        blz_pkg::CfgPayloadLen: begin
          pay_len_d    = cfg_wdata_i;
          input_left_d = cfg_wdata_i;
          bytes_owed_d = out_len_q;
        end
        blz_pkg::CfgOutputLen: begin
          out_len_d    = cfg_wdata_i;
          bytes_owed_d = cfg_wdata_i;
          input_left_d = pay_len_q;
        end
      endcase
      own_idx_d    = '0;
      flag_bits_d  = '0;
      flags_left_d = '0;
      tok_hi_d     = '0;
      phase_d      = blz_pkg::PhFlag;
      halted_d     = 1'b0;
      state_d      = SqIdle;
    end
  end

  // Output register: loaded on emission, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SqIdle;
      phase_q      <= blz_pkg::PhFlag;
      pay_len_q    <= '0;
      out_len_q    <= '0;
      bytes_owed_q <= '0;
      input_left_q <= '0;
      flag_bits_q  <= '0;
      flags_left_q <= '0;
      halted_q     <= 1'b0;
      own_idx_q    <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      pay_len_q    <= pay_len_d;
      out_len_q    <= out_len_d;
      bytes_owed_q <= bytes_owed_d;
      input_left_q <= input_left_d;
      flag_bits_q  <= flag_bits_d;
      flags_left_q <= flags_left_d;
      halted_q     <= halted_d;
      own_idx_q    <= own_idx_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Token, copy pointers and result payload.
  always_ff @(posedge clk_i) begin
    tok_hi_q   <= tok_hi_d;
    tok_lo_q   <= tok_lo_d;
    pos_q      <= pos_d;
    wr_idx_q   <= wr_idx_d;
    rd_idx_q   <= rd_idx_d;
    fin_copy_q <= fin_copy_d;
    if (emit) begin
      out_byte_q <= e_byte;
      out_pos_q  <= e_pos;
      out_last_q <= e_last;
      out_fin_q  <= e_fin;
      out_sts_q  <= e_sts;
    end
  end

  // History memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (state_q == SqRead) begin
      rd_data_q <= hist_mem[rd_idx_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign out_position_o = out_pos_q;
  assign last_of_item_o = out_last_q;
  assign finished_o     = out_fin_q;
  assign status_o       = out_sts_q;

  // A copy in progress always has bytes left to move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SqRead) || (state_q == SqWrite)) |-> (cnt_q != '0))
    else $error("copy sequencer running with an empty count");

  // Copy pointers stay inside the history memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SqRead) |-> ((wr_idx_q <= IdxMax) && (rd_idx_q <= IdxMax)))
    else $error("history index out of range");

  // A token is only evaluated while bytes are still owed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SqToken) |-> (bytes_owed_q != '0))
    else $error("token evaluated with nothing owed");

  // The word that ends the stream, flagged as finished, halts the stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && e_fin && !cfg_we_i) |=> halted_q)
    else $error("stream not halted after the final byte");

endmodule
